@@ hdl/tsc_pkg.sv @@
`default_nettype none

package tsc_pkg;

  // Field widths of the stream items.
  localparam int FUNC_W      = 4;
  localparam int IMM_W       = 7;
  localparam int DST_W       = 4;
  localparam int PC_W        = 7;
  localparam int VAL_OUT_W   = 32;
  localparam int CNT_OUT_W   = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = 3;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_MOVIMM  = 4'd0;
  localparam logic [FUNC_W-1:0] FN_MOVREG  = 4'd1;
  localparam logic [FUNC_W-1:0] FN_MUL     = 4'd2;
  localparam logic [FUNC_W-1:0] FN_ADD     = 4'd3;
  localparam logic [FUNC_W-1:0] FN_DIV     = 4'd4;
  localparam logic [FUNC_W-1:0] FN_CMP     = 4'd5;
  localparam logic [FUNC_W-1:0] FN_PUSHIMM = 4'd6;
  localparam logic [FUNC_W-1:0] FN_JNZ     = 4'd7;
  localparam logic [FUNC_W-1:0] FN_DEC     = 4'd8;
  localparam logic [FUNC_W-1:0] FN_PUSHREG = 4'd9;
  localparam logic [FUNC_W-1:0] FN_POP     = 4'd10;
  localparam logic [FUNC_W-1:0] FN_HALT    = 4'd11;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd_a;
    logic rd_b;
    logic mdu_start;
    logic commit;
  } tsc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_mdu;
    logic mdu_busy;
    logic out_free;
  } tsc_status_t;

endpackage

`default_nettype wire

@@ hdl/tsc_ram.sv @@
`default_nettype none

module tsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/tsc_mdu.sv @@
`default_nettype none

// Shared multiply and divide unit: one bit per cycle, DATA_WIDTH steps.
module tsc_mdu #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  is_div,
  input  wire logic [DATA_WIDTH-1:0] src,
  input  wire logic [DATA_WIDTH-1:0] dst,
  output logic                       busy,
  output logic      [DATA_WIDTH-1:0] result
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  logic [CNT_W-1:0]      cnt;
  logic                  div_op;
  logic                  neg;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] opnd;
  logic [DATA_WIDTH-1:0] work;
  logic [DATA_WIDTH-1:0] src_mag;
  logic [DATA_WIDTH-1:0] dst_mag;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  assign src_mag = src[DATA_WIDTH-1] ? (~src + DATA_WIDTH'(1)) : src;
  assign dst_mag = dst[DATA_WIDTH-1] ? (~dst + DATA_WIDTH'(1)) : dst;
  assign rem_sh  = {acc, work[DATA_WIDTH-1]};
  assign diff    = rem_sh - {1'b0, opnd};
  assign ge      = (rem_sh >= {1'b0, opnd});

  // Quotient sign is applied after the last step.
  assign result = div_op ? (neg ? (~work + DATA_WIDTH'(1)) : work) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      cnt    <= '0;
      div_op <= is_div;
      neg    <= src[DATA_WIDTH-1] ^ dst[DATA_WIDTH-1];
      acc    <= '0;
      opnd   <= is_div ? src_mag : src;
      work   <= is_div ? dst_mag : dst;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(DATA_WIDTH - 1)) begin
        busy <= 1'b0;
      end
      if (div_op) begin
        // Restoring division: remainder in acc, quotient shifts into work.
        acc  <= ge ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
        work <= {work[DATA_WIDTH-2:0], ge};
      end else begin
        // Shift-and-add multiply, low half only.
        if (work[0]) begin
          acc <= acc + opnd;
        end
        opnd <= {opnd[DATA_WIDTH-2:0], 1'b0};
        work <= {1'b0, work[DATA_WIDTH-1:1]};
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/tsc_ctrl.sv @@
`default_nettype none

module tsc_ctrl
  import tsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             in_ready,
  input  wire tsc_status_t status,
  output tsc_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_EXEC,
    S_ITER,
    S_WAIT,
    S_WB
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = S_RD_A;
        end
      end
      S_RD_A: begin
        cmd.rd_a   = 1'b1;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd.rd_b   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (status.need_mdu) begin
          cmd.mdu_start = 1'b1;
          state_next    = S_ITER;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_ITER: begin
        if (!status.mdu_busy) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (status.out_free) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  mdu_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mdu_start |-> !status.mdu_busy)
    else $error("multiply/divide started while the unit is busy");

  ready_after_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> in_ready)
    else $error("block not ready for an item after a commit");

endmodule

`default_nettype wire

@@ hdl/tsc_dpath.sv @@
`default_nettype none

module tsc_dpath
  import tsc_pkg::*;
#(
  parameter int NUM_REGS    = 16,
  parameter int STACK_DEPTH = 128,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire tsc_cmd_t               cmd,
  output tsc_status_t                 status,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata
);

  localparam int RA_W = $clog2(NUM_REGS);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W = $clog2(STACK_DEPTH);

  // Instruction held for the whole item.
  logic [FUNC_W-1:0] func_q;
  logic [IMM_W-1:0]  imm_q;
  logic [DST_W-1:0]  dst_q;

  // Architectural state.
  logic [NUM_REGS-1:0] rf_valid;
  logic [SP_W-1:0]     sp;
  logic [PC_W-1:0]     pc;
  logic                ovf;
  logic                neg;
  logic                zero;
  logic                ne;
  logic                halt;

  // Operands.
  logic [DATA_WIDTH-1:0] a_q;
  logic                  rf_vld_q;
  logic [DATA_WIDTH-1:0] rf_rdata;
  logic [DATA_WIDTH-1:0] st_rdata;
  logic [DATA_WIDTH-1:0] b_val;
  logic [DATA_WIDTH-1:0] imm_ext;
  logic [DATA_WIDTH-1:0] mdu_result;
  logic                  mdu_busy;

  logic            imm_ok;
  logic            dst_ok;
  logic            rf_re;
  logic [RA_W-1:0] rf_raddr;
  logic            rd_ok;
  logic            rf_we;
  logic [SP_W-1:0] sp_m1;
  logic            sp_full;
  logic            push_do;

  // Next-state values of a commit.
  logic [PC_W-1:0]       pc_next;
  logic                  wr_en;
  logic [DATA_WIDTH-1:0] wr_val;
  logic                  zn_upd;
  logic                  neg_next;
  logic                  zero_next;
  logic                  ovf_next;
  logic [SP_W-1:0]       sp_next;
  logic                  ne_next;
  logic                  halt_next;
  logic                  derr;
  logic                  push_en;
  logic [DATA_WIDTH-1:0] push_val;
  logic [DATA_WIDTH-1:0] dest_after;

  logic [DATA_WIDTH+VAL_OUT_W-1:0] val_ext;
  logic [SP_W+CNT_OUT_W-1:0]       cnt_ext;

  assign imm_ok  = ({1'b0, imm_q} < (IMM_W + 1)'(NUM_REGS));
  assign dst_ok  = ({1'b0, dst_q} < (DST_W + 1)'(NUM_REGS));
  assign imm_ext = DATA_WIDTH'(imm_q);
  assign b_val   = rf_vld_q ? rf_rdata : '0;
  assign sp_m1   = sp - SP_W'(1);
  assign sp_full = (sp == SP_W'(STACK_DEPTH));

  assign rf_re    = cmd.rd_a | cmd.rd_b;
  assign rf_raddr = cmd.rd_a ? imm_q[RA_W-1:0] : dst_q[RA_W-1:0];
  assign rd_ok    = cmd.rd_a ? imm_ok : dst_ok;

  tsc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_REGS)
  ) u_regfile (
    .clk   (clk),
    .we    (rf_we),
    .waddr (dst_q[RA_W-1:0]),
    .wdata (wr_val),
    .re    (rf_re),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  tsc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push_do),
    .waddr (sp[SA_W-1:0]),
    .wdata (push_val),
    .re    (cmd.rd_a),
    .raddr (sp_m1[SA_W-1:0]),
    .rdata (st_rdata)
  );

  tsc_mdu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mdu (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mdu_start),
    .is_div (func_q == FN_DIV),
    .src    (a_q),
    .dst    (b_val),
    .busy   (mdu_busy),
    .result (mdu_result)
  );

  assign status.need_mdu = !halt &&
                           ((func_q == FN_MUL) || ((func_q == FN_DIV) && (a_q != '0)));
  assign status.mdu_busy = mdu_busy;
  assign status.out_free = !m_tvalid || m_tready;

  always_comb begin
    pc_next   = pc + PC_W'(1);
    wr_en     = 1'b0;
    wr_val    = a_q;
    zn_upd    = 1'b0;
    neg_next  = neg;
    zero_next = zero;
    ovf_next  = ovf;
    sp_next   = sp;
    ne_next   = ne;
    halt_next = halt;
    derr      = 1'b0;
    push_en   = 1'b0;
    push_val  = imm_ext;
    if (halt) begin
      pc_next = pc;
    end else begin
      unique case (func_q)
        FN_MOVIMM: begin
          wr_en  = 1'b1;
          wr_val = imm_ext;
        end
        FN_MOVREG: begin
          wr_en  = 1'b1;
          wr_val = a_q;
        end
        FN_MUL: begin
          wr_en  = 1'b1;
          wr_val = mdu_result;
          zn_upd = 1'b1;
        end
        FN_ADD: begin
          wr_en  = 1'b1;
          wr_val = a_q + b_val;
          zn_upd = 1'b1;
        end
        FN_DIV: begin
          if (a_q == '0) begin
            derr = 1'b1;
          end else begin
            wr_en  = 1'b1;
            wr_val = mdu_result;
            zn_upd = 1'b1;
          end
        end
        FN_CMP: begin
          ne_next = (a_q != b_val);
        end
        FN_PUSHIMM: begin
          push_en  = 1'b1;
          push_val = imm_ext;
        end
        FN_JNZ: begin
          if (ne) begin
            pc_next = imm_q;
          end
        end
        FN_DEC: begin
          wr_en = 1'b1;
          if (b_val[DATA_WIDTH-1] || (b_val == '0)) begin
            wr_val    = '0;
            neg_next  = 1'b1;
            zero_next = 1'b0;
          end else begin
            wr_val    = b_val - DATA_WIDTH'(1);
            neg_next  = 1'b0;
            zero_next = (b_val == DATA_WIDTH'(1));
          end
        end
        FN_PUSHREG: begin
          push_en  = 1'b1;
          push_val = b_val;
        end
        FN_POP: begin
          if (sp != '0) begin
            sp_next = sp_m1;
            wr_en   = 1'b1;
            wr_val  = st_rdata;
          end
        end
        FN_HALT: begin
          halt_next = 1'b1;
          pc_next   = pc;
        end
        default: begin
        end
      endcase
      if (zn_upd) begin
        zero_next = (wr_val == '0);
        neg_next  = wr_val[DATA_WIDTH-1];
      end
      if (push_en) begin
        if (sp_full) begin
          ovf_next = 1'b1;
        end else begin
          sp_next  = sp + SP_W'(1);
          ovf_next = 1'b0;
        end
      end
    end
  end

  assign rf_we      = cmd.commit && wr_en && dst_ok;
  assign push_do    = cmd.commit && push_en && !sp_full;
  assign dest_after = (wr_en && dst_ok) ? wr_val : b_val;
  assign val_ext    = {{VAL_OUT_W{1'b0}}, dest_after};
  assign cnt_ext    = {{CNT_OUT_W{1'b0}}, sp_next};

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q <= s_tdata[FUNC_W-1:0];
      imm_q  <= s_tdata[FUNC_W+IMM_W-1:FUNC_W];
      dst_q  <= s_tdata[FUNC_W+IMM_W+DST_W-1:FUNC_W+IMM_W];
    end
    if (rf_re) begin
      rf_vld_q <= rd_ok && rf_valid[rf_raddr];
    end
    if (cmd.rd_b) begin
      a_q <= rf_vld_q ? rf_rdata : '0;
    end
    if (cmd.commit) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, halt_next, derr, cnt_ext[CNT_OUT_W-1:0],
                  (sp_next == '0), zero_next, neg_next, ovf_next,
                  val_ext[VAL_OUT_W-1:0], pc_next};
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      sp       <= '0;
      pc       <= '0;
      ovf      <= 1'b0;
      neg      <= 1'b0;
      zero     <= 1'b0;
      ne       <= 1'b0;
      halt     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_valid[dst_q[RA_W-1:0]] <= 1'b1;
      end
      if (cmd.commit) begin
        sp   <= sp_next;
        pc   <= pc_next;
        ovf  <= ovf_next;
        neg  <= neg_next;
        zero <= zero_next;
        ne   <= ne_next;
        halt <= halt_next;
      end
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  sp_in_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack count beyond the stack depth");

  halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halt |=> halt)
    else $error("halt cleared without reset");

  halt_holds_pc: assert property (@(posedge clk) disable iff (rst)
    halt |=> (pc == $past(pc)))
    else $error("program counter moved after halt");

  commit_has_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("result committed over an untaken result");

endmodule

`default_nettype wire

@@ hdl/toy_stack_cpu_execute.sv @@
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata: func, imm_or_src, dest_reg
// m_*       out        m_tvalid / m_tready  m_tdata: pc, dest value, flags, count
//
// One item is taken at a time, in the idle state. Each item then passes through
// register file reads at source then destination, execute, a slot check that
// waits until the output register is free, and commit into the result register.
// Multiply and divide also pass through the shared bit-serial multiply/divide
// unit between execute and the slot check.
// Reset (rst, synchronous) clears the register file valid bits, stack count,
// pc, flags and halt; no clearing pass is needed.
// A stalled result waits in the output register while the next item is taken;
// the commit of that item waits until the output register is free.

module toy_stack_cpu_execute
  import tsc_pkg::*;
#(
  parameter int NUM_REGS    = 16,
  parameter int STACK_DEPTH = 128,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // s_tdata, from bit 0: func[3:0], imm_or_src[10:4], dest_reg[14:11], zero[15]
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // m_tdata, from bit 0: program_counter[6:0], dest_value[38:7],
  // overflow_flag[39], negative_flag[40], zero_flag[41], underflow_flag[42],
  // stack_count[50:43], div_error[51], halted[52], zero[55:53]
  output logic      [OUT_TDATA_W-1:0] m_tdata
);

  // Commands and status between the sequencer and the datapath.
  tsc_cmd_t    cmd;
  tsc_status_t status;

  // The controller steps each item through read, execute and commit.
  tsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the register file, stack, flags and result register.
  tsc_dpath #(
    .NUM_REGS    (NUM_REGS),
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

@@ tb/tb_toy_stack_cpu_execute.sv @@
module tb_toy_stack_cpu_execute;
  import tsc_pkg::*;

  // The decoder leaves four function codes unassigned; the block treats them
  // as no-operations that only move the program counter on.
  localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = FN_HALT + 4'd1;
  localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 4'd15;

  localparam int NREGS      = 16;
  localparam int STACK_SIZE = 128;
  localparam int QUIET_TAIL = 200;   // final items run with no idling at all
  localparam int HOLD_AFTER = 400;   // result count at which the long hold starts
  localparam int HOLD_LEN   = 120;   // cycles the receiver holds off for
  localparam int DRAIN_CYC  = 60;    // settling time after the last result

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [IMM_W-1:0]  imm;
    logic [DST_W-1:0]  dst;
    logic              drain;      // sender waits until nothing is outstanding
  } instr_t;

  typedef struct {
    logic [PC_W-1:0]      pc;
    logic [VAL_OUT_W-1:0] value;
    logic                 ovf;
    logic                 neg;
    logic                 zero;
    logic                 unf;
    logic [CNT_OUT_W-1:0] count;
    logic                 derr;
    logic                 halted;
  } result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // s_tdata, from bit 0: func[3:0], imm_or_src[10:4], dest_reg[14:11], zero[15]
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // m_tdata, from bit 0: program_counter[6:0], dest_value[38:7], overflow_flag[39],
  // negative_flag[40], zero_flag[41], underflow_flag[42], stack_count[50:43],
  // div_error[51], halted[52], zero[55:53]
  logic [OUT_TDATA_W-1:0] m_tdata;

  toy_stack_cpu_execute dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Program waiting to be sent, and results the predictor has worked out but
  // which the block has not yet delivered.
  instr_t  program_q[$];
  result_t result_q[$];

  int n_items    = 0;
  int sent_count = 0;
  int in_count   = 0;
  int out_count  = 0;
  int err_count  = 0;

  // Shadow copy of the execution unit's architectural state.
  logic [VAL_OUT_W-1:0] shadow_regs[NREGS];
  logic [VAL_OUT_W-1:0] shadow_stack[STACK_SIZE];
  int                   shadow_sp;
  logic [PC_W-1:0]      shadow_pc;
  logic                 sh_ovf, sh_neg, sh_zero, sh_unf, sh_ne, sh_halt;

  // Figures for the closing summary.
  int stack_peak     = 0;
  int div_zero_seen  = 0;
  int refused_pushes = 0;

  result_t got, want;

  // Executes one instruction on the shadow state and queues the result item
  // the block should report for it.
  task automatic execute_instr(input logic [FUNC_W-1:0] func,
                               input logic [IMM_W-1:0] imm,
                               input logic [DST_W-1:0] dst);
    logic [VAL_OUT_W-1:0] a, b, r, ma, mb;
    logic [PC_W-1:0]      next_pc;
    logic                 derr;
    result_t              res;
    next_pc = shadow_pc + 7'd1;
    derr    = 1'b0;
    if (sh_halt) begin
      next_pc = shadow_pc;
    end else begin
      // Source indices past the register file read as zero.
      a = (imm < NREGS) ? shadow_regs[imm] : '0;
      b = shadow_regs[dst];
      case (func)
        FN_MOVIMM: shadow_regs[dst] = {25'd0, imm};
        FN_MOVREG: shadow_regs[dst] = a;
        FN_MUL, FN_ADD, FN_DIV: begin
          if (func == FN_DIV && a == '0) begin
            // Division by zero leaves the register and both flags alone.
            derr = 1'b1;
            div_zero_seen++;
          end else begin
            if (func == FN_MUL) begin
              r = a * b;
            end else if (func == FN_ADD) begin
              r = a + b;
            end else begin
              // Truncating division on magnitudes; the most negative value
              // divided by minus one simply wraps back to itself.
              ma = a[31] ? (~a + 32'd1) : a;
              mb = b[31] ? (~b + 32'd1) : b;
              r  = mb / ma;
              if (a[31] ^ b[31]) r = ~r + 32'd1;
            end
            shadow_regs[dst] = r;
            sh_zero = (r == '0);
            sh_neg  = r[31];
          end
        end
        FN_CMP: sh_ne = (a != b);
        FN_JNZ: if (sh_ne) next_pc = imm;
        FN_DEC: begin
          // Decrement saturates at zero and reports the clamp as negative.
          if (b[31] || b == '0) begin
            shadow_regs[dst] = '0;
            sh_neg  = 1'b1;
            sh_zero = 1'b0;
          end else begin
            shadow_regs[dst] = b - 32'd1;
            sh_neg  = 1'b0;
            sh_zero = (b == 32'd1);
          end
        end
        FN_PUSHIMM, FN_PUSHREG: begin
          if (shadow_sp >= STACK_SIZE) begin
            sh_ovf = 1'b1;
            refused_pushes++;
          end else begin
            shadow_stack[shadow_sp] = (func == FN_PUSHIMM) ? {25'd0, imm} : b;
            shadow_sp++;
            sh_ovf = 1'b0;
            if (shadow_sp > stack_peak) stack_peak = shadow_sp;
          end
        end
        FN_POP: begin
          if (shadow_sp > 0) begin
            shadow_sp--;
            shadow_regs[dst] = shadow_stack[shadow_sp];
          end
        end
        FN_HALT: begin
          sh_halt = 1'b1;
          next_pc = shadow_pc;
        end
        default: ;
      endcase
    end
    shadow_pc = next_pc;
    sh_unf    = (shadow_sp == 0);
    res.pc     = shadow_pc;
    res.value  = shadow_regs[dst];
    res.ovf    = sh_ovf;
    res.neg    = sh_neg;
    res.zero   = sh_zero;
    res.unf    = sh_unf;
    res.count  = shadow_sp[CNT_OUT_W-1:0];
    res.derr   = derr;
    res.halted = sh_halt;
    result_q.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("item %0d: %s expected %0h, got %0h", out_count, name, exp_v, act_v);
      err_count++;
    end
  endtask

  task automatic add_item(input logic [FUNC_W-1:0] func, input logic [IMM_W-1:0] imm,
                          input logic [DST_W-1:0] dst, input logic drain = 1'b0);
    instr_t it;
    it.func  = func;
    it.imm   = imm;
    it.dst   = dst;
    it.drain = drain;
    program_q.push_back(it);
  endtask

  // Register source indices are mostly in range; now and then one points past
  // the register file and so reads as zero.
  function automatic logic [IMM_W-1:0] pick_src();
    if ($urandom_range(0, 99) < 85) return IMM_W'($urandom_range(0, NREGS - 1));
    return IMM_W'($urandom_range(NREGS, 127));
  endfunction

  // Idling is switched off in every third window of 150 items, and for the
  // whole of the final stretch, so that back-to-back traffic is covered too.
  function automatic bit idle_allowed();
    return (in_count < n_items - QUIET_TAIL) && ((in_count / 150) % 3 != 2);
  endfunction

  // Sender: offers the next item at the falling edge once the previous one
  // has been taken, with random gaps in between.
  int gap_left = 0;
  always @(negedge clk) begin
    instr_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (sent_count != in_count) begin
      // The item on offer has not been taken yet; keep it steady.
    end else if (gap_left > 0) begin
      gap_left--;
      s_tvalid <= 1'b0;
    end else if (program_q.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (program_q[0].drain && result_q.size() != 0) begin
      // Pause until every outstanding result has come back.
      s_tvalid <= 1'b0;
    end else if (idle_allowed() && $urandom_range(0, 4) == 0) begin
      gap_left = $urandom_range(0, 4);
      s_tvalid <= 1'b0;
    end else begin
      it = program_q.pop_front();
      s_tvalid <= 1'b1;
      s_tdata  <= {1'b0, it.dst, it.imm, it.func};
      sent_count++;
    end
  end

  // Receiver: random stalls in short bursts, plus one long hold-off while the
  // sender keeps offering, so that the block backs up and stalls its input.
  int  stall_left = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && out_count >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor and predictor. The output is checked before the input is taken
  // into the predictor, so that a fresh expectation never pairs with a result
  // that was already on its way.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.pc     = m_tdata[6:0];
        got.value  = m_tdata[38:7];
        got.ovf    = m_tdata[39];
        got.neg    = m_tdata[40];
        got.zero   = m_tdata[41];
        got.unf    = m_tdata[42];
        got.count  = m_tdata[50:43];
        got.derr   = m_tdata[51];
        got.halted = m_tdata[52];
        out_count++;
        if (result_q.size() == 0) begin
          $error("result item %0d arrived with nothing expected", out_count);
          err_count++;
        end else begin
          want = result_q.pop_front();
          check_field("program_counter", 32'(want.pc), 32'(got.pc));
          check_field("dest_value", want.value, got.value);
          check_field("overflow_flag", 32'(want.ovf), 32'(got.ovf));
          check_field("negative_flag", 32'(want.neg), 32'(got.neg));
          check_field("zero_flag", 32'(want.zero), 32'(got.zero));
          check_field("underflow_flag", 32'(want.unf), 32'(got.unf));
          check_field("stack_count", 32'(want.count), 32'(got.count));
          check_field("div_error", 32'(want.derr), 32'(got.derr));
          check_field("halted", 32'(want.halted), 32'(got.halted));
        end
      end
      if (s_tvalid && s_tready) begin
        execute_instr(s_tdata[3:0], s_tdata[10:4], s_tdata[14:11]);
        in_count++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int                k;
    int                sel;
    logic [FUNC_W-1:0] f;
    logic [IMM_W-1:0]  src;

    for (k = 0; k < NREGS; k++) shadow_regs[k] = '0;
    for (k = 0; k < STACK_SIZE; k++) shadow_stack[k] = '0;
    shadow_sp = 0;
    shadow_pc = '0;
    {sh_ovf, sh_neg, sh_zero, sh_unf, sh_ne, sh_halt} = '0;

    // Directed part. Build the most negative value by repeated multiplication,
    // then take it through the signed division corner cases.
    add_item(FN_MOVIMM, 7'd64, 4'd1);
    add_item(FN_MOVREG, 7'd1, 4'd2);
    add_item(FN_MUL, 7'd2, 4'd2);       // 2^12
    add_item(FN_MUL, 7'd2, 4'd2);       // 2^24
    add_item(FN_MUL, 7'd1, 4'd2);       // 2^30
    add_item(FN_MOVREG, 7'd2, 4'd4);
    add_item(FN_MOVIMM, 7'd2, 4'd5);
    add_item(FN_MUL, 7'd5, 4'd2);       // most negative value
    add_item(FN_MOVREG, 7'd2, 4'd3);
    add_item(FN_DIV, 7'd4, 4'd3);       // -2
    add_item(FN_DIV, 7'd5, 4'd3);       // -1
    add_item(FN_DIV, 7'd3, 4'd2);       // most negative over minus one wraps
    add_item(FN_DIV, 7'd0, 4'd2);       // zero register as divisor
    add_item(FN_DIV, 7'd100, 4'd2);     // out-of-range divisor reads as zero
    add_item(FN_ADD, 7'd2, 4'd2);       // wraps round to zero
    add_item(FN_CMP, 7'd4, 4'd1);
    add_item(FN_JNZ, 7'd127, 4'd0);     // taken, and the pc then wraps
    add_item(FN_MOVIMM, 7'd1, 4'd9);
    add_item(FN_DEC, 7'd0, 4'd9);       // one down to zero
    add_item(FN_DEC, 7'd0, 4'd9);       // clamps at zero
    add_item(FN_DEC, 7'd0, 4'd3);       // negative clamps to zero
    add_item(FN_PUSHIMM, 7'd127, 4'd15);
    add_item(FN_PUSHREG, 7'd0, 4'd4);
    add_item(FN_POP, 7'd0, 4'd10);
    add_item(FN_POP, 7'd0, 4'd11);
    add_item(FN_POP, 7'd0, 4'd12);      // empty stack, register untouched
    add_item(FN_CMP, 7'd127, 4'd0);     // equal
    add_item(FN_JNZ, 7'd5, 4'd0);       // not taken
    add_item(FN_SPARE_LAST, 7'd127, 4'd15);

    // Random part: a weighted mix of operations, with a burst of pushes that
    // runs the stack into its full state and a burst of pops that empties it.
    for (k = 0; k < 1400; k++) begin
      if (k == 500)
        repeat (STACK_SIZE + 12)
          add_item($urandom_range(0, 1) ? FN_PUSHIMM : FN_PUSHREG,
                   IMM_W'($urandom_range(0, 127)), DST_W'($urandom_range(0, 15)));
      if (k == 800)
        repeat (STACK_SIZE + 12)
          add_item(FN_POP, IMM_W'($urandom_range(0, 127)), DST_W'($urandom_range(0, 15)));
      sel = $urandom_range(0, 99);
      if      (sel < 8)  f = FN_MOVIMM;
      else if (sel < 14) f = FN_MOVREG;
      else if (sel < 23) f = FN_MUL;
      else if (sel < 34) f = FN_ADD;
      else if (sel < 45) f = FN_DIV;
      else if (sel < 52) f = FN_CMP;
      else if (sel < 59) f = FN_PUSHIMM;
      else if (sel < 66) f = FN_JNZ;
      else if (sel < 74) f = FN_DEC;
      else if (sel < 81) f = FN_PUSHREG;
      else if (sel < 97) f = FN_POP;
      else               f = FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
      if (f == FN_MOVIMM || f == FN_PUSHIMM || f == FN_JNZ || f >= FN_SPARE_FIRST)
        src = IMM_W'($urandom_range(0, 127));
      else
        src = pick_src();
      add_item(f, src, DST_W'($urandom_range(0, 15)), k == 300 || k == 1200);
    end

    // Halt, then a few items that must leave the state untouched.
    add_item(FN_HALT, IMM_W'($urandom_range(0, 127)), DST_W'($urandom_range(0, 15)));
    add_item(FN_DIV, 7'd100, 4'd1);
    add_item(FN_PUSHIMM, 7'd9, 4'd2);
    add_item(FN_JNZ, 7'd3, 4'd3);
    add_item(FN_MOVIMM, 7'd77, 4'd15);
    n_items = program_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(in_count == n_items && result_q.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Summary: %0d instructions executed and %0d results checked.",
             in_count, out_count);
    $display("Summary: stack peak %0d, %0d refused pushes, %0d divisions by zero.",
             stack_peak, refused_pushes, div_zero_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of this program.
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tsc_pkg.sv
hdl/tsc_ram.sv
hdl/tsc_mdu.sv
hdl/tsc_ctrl.sv
hdl/tsc_dpath.sv
hdl/toy_stack_cpu_execute.sv
tb/tb_toy_stack_cpu_execute.sv
